// ===== sv/ggp_pkg.sv =====
package ggp_pkg;

    localparam int GRID_SIZE_DEF = 32;
    localparam int PATH_LEN_DEF  = 32;

    localparam logic [31:0] FREE_CELL = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_PATH  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_WRITE,
        OP_RD_ADDR,
        OP_SWEEP,
        OP_STEP_INIT,
        OP_SCAN,
        OP_SCAN_TAIL,
        OP_EMIT_READ,
        OP_EMIT_ECHO,
        OP_EMIT_ERR,
        OP_EMIT_STEP
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_MODE,
        COND_BAD,
        COND_STEP_MORE
    } cond_t;

    typedef logic [3:0] upc_t;

    localparam upc_t UA_IDLE  = 4'd0;
    localparam upc_t UA_WRITE = 4'd1;
    localparam upc_t UA_READ  = 4'd2;
    localparam upc_t UA_CLEAR = 4'd3;
    localparam upc_t UA_PATH  = 4'd4;
    localparam upc_t UA_SCAN  = 4'd5;
    localparam upc_t UA_RDOUT = 4'd6;
    localparam upc_t UA_ECHO  = 4'd7;
    localparam upc_t UA_ERR   = 4'd8;
    localparam upc_t UA_TAIL  = 4'd9;
    localparam upc_t UA_STEP  = 4'd10;
    localparam upc_t UA_DONE  = 4'd11;
    localparam upc_t UA_BOOT  = 4'd12;

    typedef struct packed {
        op_t   op;
        logic  emit;
        cond_t cond;
        upc_t  target;
    } ctl_t;

    typedef struct packed {
        logic bad;
        logic walk_done;
        logic scan_last;
        logic sweep_last;
        logic out_block;
    } stat_t;

    function automatic ctl_t ucode(input upc_t addr);
        ctl_t w;
        case (addr)
            UA_IDLE:  w = '{op: OP_ACCEPT,    emit: 1'b0, cond: COND_MODE,      target: UA_WRITE};
            UA_WRITE: w = '{op: OP_WRITE,     emit: 1'b1, cond: COND_ALWAYS,    target: UA_IDLE};
            UA_READ:  w = '{op: OP_RD_ADDR,   emit: 1'b0, cond: COND_ALWAYS,    target: UA_RDOUT};
            UA_CLEAR: w = '{op: OP_SWEEP,     emit: 1'b0, cond: COND_ALWAYS,    target: UA_ECHO};
            UA_PATH:  w = '{op: OP_STEP_INIT, emit: 1'b0, cond: COND_BAD,       target: UA_ERR};
            UA_SCAN:  w = '{op: OP_SCAN,      emit: 1'b0, cond: COND_ALWAYS,    target: UA_TAIL};
            UA_RDOUT: w = '{op: OP_EMIT_READ, emit: 1'b1, cond: COND_ALWAYS,    target: UA_IDLE};
            UA_ECHO:  w = '{op: OP_EMIT_ECHO, emit: 1'b1, cond: COND_ALWAYS,    target: UA_IDLE};
            UA_ERR:   w = '{op: OP_EMIT_ERR,  emit: 1'b1, cond: COND_ALWAYS,    target: UA_IDLE};
            UA_TAIL:  w = '{op: OP_SCAN_TAIL, emit: 1'b0, cond: COND_NONE,      target: UA_IDLE};
            UA_STEP:  w = '{op: OP_EMIT_STEP, emit: 1'b1, cond: COND_STEP_MORE, target: UA_SCAN};
            UA_DONE:  w = '{op: OP_NOP,       emit: 1'b0, cond: COND_ALWAYS,    target: UA_IDLE};
            UA_BOOT:  w = '{op: OP_SWEEP,     emit: 1'b0, cond: COND_ALWAYS,    target: UA_IDLE};
            default:  w = '{op: OP_NOP,       emit: 1'b0, cond: COND_ALWAYS,    target: UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/grid_greedy_path_finder.sv =====
// channel   handshake              payload
// request   req_valid / req_ready  mode, cell_x, cell_y, goal_x, goal_y, cell_value
// result    res_valid / res_ready  pos_x, pos_y, read_value, error, last
//
// A write is accepted, then written and answered; a read is addressed, then answered.
// Clear writes every grid word free, one grid word per cycle, then answers.
// A walk reads eight neighbours per step through the single RAM read port,
// then does one final compare and emits one result per step.
// After reset the grid is swept free; req_ready stays low meanwhile.
// A stalled result holds the sequencer at its result step.
module grid_greedy_path_finder
    import ggp_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF,
    parameter int PATH_LEN  = PATH_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  cell_x,
    input  logic [7:0]  cell_y,
    input  logic [7:0]  goal_x,
    input  logic [7:0]  goal_y,
    input  logic [31:0] cell_value,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [7:0]  pos_x,
    output logic [7:0]  pos_y,
    output logic [31:0] read_value,
    output logic        error,
    output logic        last
);

    ctl_t  ctl;
    stat_t stat;

    ggp_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .mode      (mode),
        .stat      (stat),
        .ctl       (ctl),
        .req_ready (req_ready)
    );

    ggp_datapath #(
        .GRID_SIZE (GRID_SIZE),
        .PATH_LEN  (PATH_LEN)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .req_valid  (req_valid),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .goal_x     (goal_x),
        .goal_y     (goal_y),
        .cell_value (cell_value),
        .stat       (stat),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .read_value (read_value),
        .error      (error),
        .last       (last)
    );

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while previous one in progress");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && error) |-> last)
        else $error("error result not marked last");

    a_scan_runs: assert property (@(posedge clk) disable iff (!rst_n)
        ((ctl.op == OP_SCAN) && !stat.scan_last) |=> (ctl.op == OP_SCAN))
        else $error("neighbour scan left early");

endmodule

// ===== sv/ggp_sequencer.sv =====
module ggp_sequencer
    import ggp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [1:0] mode,
    input  stat_t      stat,
    output ctl_t       ctl,
    output logic       req_ready
);

    upc_t upc_reg;
    upc_t upc_next;
    upc_t upc_inc;
    logic hold;

    assign ctl       = ucode(upc_reg);
    assign req_ready = (ctl.op == OP_ACCEPT);
    assign upc_inc   = upc_reg + upc_t'(1);

    // hold on an empty request, a full result slot, or a repeating word
    assign hold = ((ctl.op == OP_ACCEPT) && !req_valid)
               || (ctl.emit && stat.out_block)
               || ((ctl.op == OP_SCAN) && !stat.scan_last)
               || ((ctl.op == OP_SWEEP) && !stat.sweep_last);

    always_comb
    begin
        upc_next = upc_reg;
        if (!hold)
        begin
            case (ctl.cond)
                COND_NONE:      upc_next = upc_inc;
                COND_ALWAYS:    upc_next = ctl.target;
                COND_MODE:      upc_next = ctl.target + {2'b00, mode};
                COND_BAD:       upc_next = stat.bad ? ctl.target : upc_inc;
                COND_STEP_MORE: upc_next = stat.walk_done ? upc_inc : ctl.target;
                default:        upc_next = UA_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_BOOT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== sv/ggp_datapath.sv =====
module ggp_datapath
    import ggp_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF,
    parameter int PATH_LEN  = PATH_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    input  logic        req_valid,
    input  logic [7:0]  cell_x,
    input  logic [7:0]  cell_y,
    input  logic [7:0]  goal_x,
    input  logic [7:0]  goal_y,
    input  logic [31:0] cell_value,
    output stat_t       stat,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [7:0]  pos_x,
    output logic [7:0]  pos_y,
    output logic [31:0] read_value,
    output logic        error,
    output logic        last
);

    localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int STEP_W = $clog2(PATH_LEN + 1);

    function automatic logic in_grid(input logic [8:0] x, input logic [8:0] y);
        return (x < 9'(GRID_SIZE)) && (y < 9'(GRID_SIZE));
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // offset code 0, 1, 2 stands for -1, 0, +1; scan row above, same row, row below
    function automatic logic [1:0] nbr_dx(input logic [2:0] idx);
        logic [1:0] c;
        case (idx)
            3'd0, 3'd3, 3'd5: c = 2'd0;
            3'd1, 3'd6:       c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] nbr_dy(input logic [2:0] idx);
        logic [1:0] c;
        case (idx)
            3'd0, 3'd1, 3'd2: c = 2'd0;
            3'd3, 3'd4:       c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    logic [31:0] mem [DEPTH];
    logic [31:0] mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic [7:0]        pos_x_reg, pos_x_next;
    logic [7:0]        pos_y_reg, pos_y_next;
    logic [7:0]        goal_x_reg, goal_x_next;
    logic [7:0]        goal_y_reg, goal_y_next;
    logic [31:0]       value_reg, value_next;
    logic [2:0]        nbr_idx_reg, nbr_idx_next;
    logic              cand_valid_reg, cand_valid_next;
    logic [7:0]        cand_x_reg, cand_x_next;
    logic [7:0]        cand_y_reg, cand_y_next;
    logic [8:0]        cand_dist_reg, cand_dist_next;
    logic              found_reg, found_next;
    logic [7:0]        best_x_reg, best_x_next;
    logic [7:0]        best_y_reg, best_y_next;
    logic [8:0]        best_dist_reg, best_dist_next;
    logic [STEP_W-1:0] step_cnt_reg, step_cnt_next;
    logic [ADDR_W-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic              res_valid_reg, res_valid_next;
    logic [7:0]        res_x_reg, res_x_next;
    logic [7:0]        res_y_reg, res_y_next;
    logic [31:0]       res_value_reg, res_value_next;
    logic              res_error_reg, res_error_next;
    logic              res_last_reg, res_last_next;

    logic [8:0]        nx9, ny9;
    logic              nbr_in;
    logic [ADDR_W-1:0] nbr_addr;
    logic [ADDR_W-1:0] pos_addr;
    logic [8:0]        nbr_dist;
    logic              pos_ok, goal_ok;
    logic              better;
    logic [7:0]        step_x, step_y;
    logic              walk_done;
    logic              out_block;
    logic              fire;
    logic              sweep_last;

    assign nx9      = {1'b0, pos_x_reg} + {7'b0, nbr_dx(nbr_idx_reg)} - 9'd1;
    assign ny9      = {1'b0, pos_y_reg} + {7'b0, nbr_dy(nbr_idx_reg)} - 9'd1;
    assign nbr_in   = in_grid(nx9, ny9);
    assign nbr_addr = ADDR_W'(int'(ny9) * GRID_SIZE + int'(nx9));
    assign pos_addr = ADDR_W'(int'(pos_y_reg) * GRID_SIZE + int'(pos_x_reg));
    assign nbr_dist = {1'b0, abs_diff(nx9[7:0], goal_x_reg)}
                    + {1'b0, abs_diff(ny9[7:0], goal_y_reg)};
    assign pos_ok   = in_grid({1'b0, pos_x_reg}, {1'b0, pos_y_reg});
    assign goal_ok  = in_grid({1'b0, goal_x_reg}, {1'b0, goal_y_reg});

    assign better = cand_valid_reg && (mem_rdata_reg == FREE_CELL)
                 && (!found_reg || (cand_dist_reg < best_dist_reg));

    assign step_x    = found_reg ? best_x_reg : pos_x_reg;
    assign step_y    = found_reg ? best_y_reg : pos_y_reg;
    assign walk_done = ((step_x == goal_x_reg) && (step_y == goal_y_reg))
                    || (step_cnt_reg == STEP_W'(PATH_LEN - 1));

    assign out_block  = res_valid_reg && !res_ready;
    assign fire       = !(ctl.emit && out_block);
    assign sweep_last = (sweep_cnt_reg == ADDR_W'(DEPTH - 1));

    assign stat = '{bad:        !(pos_ok && goal_ok),
                    walk_done:  walk_done,
                    scan_last:  (nbr_idx_reg == 3'd7),
                    sweep_last: sweep_last,
                    out_block:  out_block};

    always_comb
    begin
        mem_we          = 1'b0;
        mem_waddr       = pos_addr;
        mem_wdata       = value_reg;
        mem_raddr       = pos_addr;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        goal_x_next     = goal_x_reg;
        goal_y_next     = goal_y_reg;
        value_next      = value_reg;
        nbr_idx_next    = nbr_idx_reg;
        cand_valid_next = cand_valid_reg;
        cand_x_next     = cand_x_reg;
        cand_y_next     = cand_y_reg;
        cand_dist_next  = cand_dist_reg;
        found_next      = found_reg;
        best_x_next     = best_x_reg;
        best_y_next     = best_y_reg;
        best_dist_next  = best_dist_reg;
        step_cnt_next   = step_cnt_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_value_next  = res_value_reg;
        res_error_next  = res_error_reg;
        res_last_next   = res_last_reg;

        if (fire)
        begin
            case (ctl.op)
                OP_ACCEPT:
                begin
                    if (req_valid)
                    begin
                        pos_x_next     = cell_x;
                        pos_y_next     = cell_y;
                        goal_x_next    = goal_x;
                        goal_y_next    = goal_y;
                        value_next     = cell_value;
                        step_cnt_next  = '0;
                        sweep_cnt_next = '0;
                    end
                end
                OP_WRITE:
                begin
                    mem_we         = pos_ok;
                    res_valid_next = 1'b1;
                    res_x_next     = pos_x_reg;
                    res_y_next     = pos_y_reg;
                    res_value_next = '0;
                    res_error_next = !pos_ok;
                    res_last_next  = 1'b1;
                end
                OP_RD_ADDR:
                begin
                    mem_raddr = pos_addr;
                end
                OP_SWEEP:
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = sweep_cnt_reg;
                    mem_wdata      = FREE_CELL;
                    sweep_cnt_next = sweep_last ? '0 : sweep_cnt_reg + ADDR_W'(1);
                end
                OP_STEP_INIT:
                begin
                    nbr_idx_next    = '0;
                    found_next      = 1'b0;
                    cand_valid_next = 1'b0;
                end
                OP_SCAN, OP_SCAN_TAIL:
                begin
                    if (better)
                    begin
                        found_next     = 1'b1;
                        best_x_next    = cand_x_reg;
                        best_y_next    = cand_y_reg;
                        best_dist_next = cand_dist_reg;
                    end
                    if (ctl.op == OP_SCAN)
                    begin
                        mem_raddr       = nbr_addr;
                        cand_valid_next = nbr_in;
                        cand_x_next     = nx9[7:0];
                        cand_y_next     = ny9[7:0];
                        cand_dist_next  = nbr_dist;
                        nbr_idx_next    = nbr_idx_reg + 3'd1;
                    end
                    else
                    begin
                        cand_valid_next = 1'b0;
                    end
                end
                OP_EMIT_READ:
                begin
                    res_valid_next = 1'b1;
                    res_x_next     = pos_x_reg;
                    res_y_next     = pos_y_reg;
                    res_value_next = pos_ok ? mem_rdata_reg : '0;
                    res_error_next = !pos_ok;
                    res_last_next  = 1'b1;
                end
                OP_EMIT_ECHO, OP_EMIT_ERR:
                begin
                    res_valid_next = 1'b1;
                    res_x_next     = pos_x_reg;
                    res_y_next     = pos_y_reg;
                    res_value_next = '0;
                    res_error_next = (ctl.op == OP_EMIT_ERR);
                    res_last_next  = 1'b1;
                end
                OP_EMIT_STEP:
                begin
                    res_valid_next  = 1'b1;
                    res_x_next      = step_x;
                    res_y_next      = step_y;
                    res_value_next  = '0;
                    res_error_next  = 1'b0;
                    res_last_next   = walk_done;
                    pos_x_next      = step_x;
                    pos_y_next      = step_y;
                    step_cnt_next   = step_cnt_reg + STEP_W'(1);
                    nbr_idx_next    = '0;
                    found_next      = 1'b0;
                    cand_valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nbr_idx_reg    <= '0;
            cand_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            step_cnt_reg   <= '0;
            sweep_cnt_reg  <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            nbr_idx_reg    <= nbr_idx_next;
            cand_valid_reg <= cand_valid_next;
            found_reg      <= found_next;
            step_cnt_reg   <= step_cnt_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg     <= pos_x_next;
        pos_y_reg     <= pos_y_next;
        goal_x_reg    <= goal_x_next;
        goal_y_reg    <= goal_y_next;
        value_reg     <= value_next;
        cand_x_reg    <= cand_x_next;
        cand_y_reg    <= cand_y_next;
        cand_dist_reg <= cand_dist_next;
        best_x_reg    <= best_x_next;
        best_y_reg    <= best_y_next;
        best_dist_reg <= best_dist_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_value_reg <= res_value_next;
        res_error_reg <= res_error_next;
        res_last_reg  <= res_last_next;
    end

    assign res_valid  = res_valid_reg;
    assign pos_x      = res_x_reg;
    assign pos_y      = res_y_reg;
    assign read_value = res_value_reg;
    assign error      = res_error_reg;
    assign last       = res_last_reg;

endmodule
